// ===== rtl/pressure_temperature_compensation_core_assert.svh =====
// Assertion macros used by the checker module ptc_chk.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_CORE_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ptc check failed");

// Consequent must hold in the cycle after the antecedent.
`define PTC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ptc check failed");

`endif

// ===== rtl/ptc_pkg.sv =====
`timescale 1ns / 1ps
package ptc_pkg;

	localparam int DATA_W  = 64;
	localparam int CFG_W   = 48;
	localparam int MUL_LAT = 2;
	localparam int LAT     = 84;

	localparam logic [63:0] TFINE_OFFSET = 64'd128000;
	localparam logic [63:0] PRESS_FULL   = 64'd1048576;
	localparam logic [63:0] PRESS_SCALE  = 64'd3125;
	localparam logic [63:0] VAR1_BIAS    = 64'h0000_8000_0000_0000;

	typedef enum logic [1:0] {
		REG_TEMP_CALIB    = 2'd0,
		REG_PRESS_CALIB_A = 2'd1,
		REG_PRESS_CALIB_B = 2'd2,
		REG_PRESS_CALIB_C = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] temperature_centi;
		logic [31:0]        pressure_q24_8;
		logic               divisor_zero;
	} out_item_t;

	function automatic logic [63:0] sext16(input logic [15:0] w);
		return {{48{w[15]}}, w};
	endfunction

endpackage

// ===== rtl/ptc_mul64.sv =====
`timescale 1ns / 1ps
// 64 x 64 multiply, low 64 bits kept, two register stages.
module ptc_mul64
	import ptc_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);

	logic [63:0] ll_s1;
	logic [31:0] lh_s1;
	logic [31:0] hl_s1;
	logic [63:0] lh_full;
	logic [63:0] hl_full;
	logic [31:0] cross_sum;

	assign lh_full   = a[31:0] * b[63:32];
	assign hl_full   = a[63:32] * b[31:0];
	assign cross_sum = lh_s1 + hl_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= a[31:0] * b[31:0];
			lh_s1 <= lh_full[31:0];
			hl_s1 <= hl_full[31:0];
			p     <= ll_s1 + {cross_sum, 32'b0};
		end
	end

endmodule

// ===== rtl/ptc_dly.sv =====
`timescale 1ns / 1ps
// Shift line of registers that moves a value along only while en is high.
module ptc_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < N; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign q = tap_q[N-1];

endmodule

// ===== rtl/ptc_div.sv =====
`timescale 1ns / 1ps
// Unsigned restoring divider, one quotient bit per stage.
module ptc_div
	import ptc_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [DATA_W-1:0] num,
	input  logic [DATA_W-1:0] den,
	output logic [DATA_W-1:0] quo
);

	logic [DATA_W-1:0] rem_q [DATA_W];
	logic [DATA_W-1:0] nq_q  [DATA_W];
	logic [DATA_W-1:0] den_q [DATA_W];
	logic [DATA_W-1:0] rem_in [DATA_W];
	logic [DATA_W-1:0] nq_in  [DATA_W];
	logic [DATA_W-1:0] den_in [DATA_W];
	logic [DATA_W:0]   shifted [DATA_W];
	logic [DATA_W:0]   trial   [DATA_W];

	always_comb begin
		for (int i = 0; i < DATA_W; i++) begin
			if (i == 0) begin
				rem_in[i] = '0;
				nq_in[i]  = num;
				den_in[i] = den;
			end else begin
				rem_in[i] = rem_q[i-1];
				nq_in[i]  = nq_q[i-1];
				den_in[i] = den_q[i-1];
			end
			shifted[i] = {rem_in[i], nq_in[i][DATA_W-1]};
			trial[i]   = shifted[i] - {1'b0, den_in[i]};
		end
	end

	// Shift the numerator out and the quotient bit in at the bottom.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < DATA_W; i++) begin
				rem_q[i] <= trial[i][DATA_W] ? shifted[i][DATA_W-1:0] : trial[i][DATA_W-1:0];
				nq_q[i]  <= {nq_in[i][DATA_W-2:0], ~trial[i][DATA_W]};
				den_q[i] <= den_in[i];
			end
		end
	end

	assign quo = nq_q[DATA_W-1];

endmodule

// ===== rtl/pressure_temperature_compensation_core.sv =====
// Pressure / temperature compensation core.
// Input channel in_valid/in_ready/in_data carries one beat of raw 20-bit
// temperature and pressure readings; output channel out_valid/out_ready/
// out_data returns one beat per input: temperature in 0.01 degC, pressure
// in Pa as unsigned Q24.8, and a flag when the pressure divisor was zero.
// Calibration words come in on cfg_valid/cfg_ready/cfg_index/cfg_data,
// three 16-bit words per 48-bit register; cfg_ready is always high. Write
// them only while no beat is in flight.
// Throughput is one beat per cycle while no result waits unclaimed at the
// output. Depth is set by the 64-stage divider (one quotient bit per stage)
// plus five two-stage 64-bit multiplier steps in series and single-register stages such as the temperature path.
// Reset clears all valid bits and the calibration registers to zero.
// When out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
module pressure_temperature_compensation_core
	import ptc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	// Calibration registers
	logic [CFG_W-1:0] temp_calib_q;
	logic [CFG_W-1:0] press_a_q;
	logic [CFG_W-1:0] press_b_q;
	logic [CFG_W-1:0] press_c_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q <= '0;
			press_a_q    <= '0;
			press_b_q    <= '0;
			press_c_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TEMP_CALIB:    temp_calib_q <= cfg_data;
				REG_PRESS_CALIB_A: press_a_q    <= cfg_data;
				REG_PRESS_CALIB_B: press_b_q    <= cfg_data;
				REG_PRESS_CALIB_C: press_c_q    <= cfg_data;
				default:           ;
			endcase
		end
	end

	// Calibration words
	logic [15:0]        t1;
	logic signed [15:0] t2;
	logic signed [15:0] t3;
	logic [63:0]        p1, p2, p3, p4, p5, p6, p7, p8, p9;

	assign t1 = temp_calib_q[15:0];
	assign t2 = $signed(temp_calib_q[31:16]);
	assign t3 = $signed(temp_calib_q[47:32]);
	assign p1 = {48'b0, press_a_q[15:0]};
	assign p2 = sext16(press_a_q[31:16]);
	assign p3 = sext16(press_a_q[47:32]);
	assign p4 = sext16(press_b_q[15:0]);
	assign p5 = sext16(press_b_q[31:16]);
	assign p6 = sext16(press_b_q[47:32]);
	assign p7 = sext16(press_c_q[15:0]);
	assign p8 = sext16(press_c_q[31:16]);
	assign p9 = sext16(press_c_q[47:32]);

	// Global advance: hold everything while a result waits unclaimed.
	logic en;
	logic [LAT-1:0] vld_q;

	assign out_valid = vld_q[LAT-1];
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// Stage 1: temperature differences and first products (32-bit wrap)
	logic signed [17:0] d1;
	logic signed [16:0] d2;
	logic signed [33:0] m1;
	logic signed [33:0] m2;
	logic signed [31:0] a_s1;
	logic signed [31:0] tsq_s1;

	assign d1 = $signed({1'b0, in_data.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
	assign d2 = $signed({1'b0, in_data.raw_temperature[19:4]}) - $signed({1'b0, t1});
	assign m1 = 34'(d1) * 34'(t2);
	assign m2 = 34'(d2) * 34'(d2);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= $signed(m1[31:0]) >>> 11;
			tsq_s1 <= $signed(m2[31:0]) >>> 12;
		end
	end

	// Stage 2: fine temperature
	logic signed [47:0] m3;
	logic signed [31:0] b_t;
	logic signed [31:0] fine_s2;

	assign m3  = 48'(tsq_s1) * 48'(t3);
	assign b_t = $signed(m3[31:0]) >>> 14;

	always_ff @(posedge clk) begin
		if (en) begin
			fine_s2 <= a_s1 + b_t;
		end
	end

	// Stage 3: temperature result and pressure offset
	logic signed [31:0] f5;
	logic signed [31:0] temp_s3;
	logic [63:0]        v1_s3;

	assign f5 = (fine_s2 <<< 2) + fine_s2 + 32'sd128;

	always_ff @(posedge clk) begin
		if (en) begin
			temp_s3 <= f5 >>> 8;
			v1_s3   <= {{32{fine_s2[31]}}, fine_s2} - TFINE_OFFSET;
		end
	end

	// Stages 4-5: v1 squared, v1*P5, v1*P2
	logic [63:0] sq;
	logic [63:0] v1p5;
	logic [63:0] v1p2;

	ptc_mul64 u_mul_sq (.clk(clk), .en(en), .a(v1_s3), .b(v1_s3), .p(sq));
	ptc_mul64 u_mul_p5 (.clk(clk), .en(en), .a(v1_s3), .b(p5), .p(v1p5));
	ptc_mul64 u_mul_p2 (.clk(clk), .en(en), .a(v1_s3), .b(p2), .p(v1p2));

	// Stages 6-7: square times P6 and P3
	logic [63:0] sqp6;
	logic [63:0] sqp3;
	logic [63:0] v1p5_d;
	logic [63:0] v1p2_d;

	ptc_mul64 u_mul_p6 (.clk(clk), .en(en), .a(sq), .b(p6), .p(sqp6));
	ptc_mul64 u_mul_p3 (.clk(clk), .en(en), .a(sq), .b(p3), .p(sqp3));
	ptc_dly #(.W(64), .N(MUL_LAT)) u_dly_v1p5 (.clk(clk), .en(en), .d(v1p5), .q(v1p5_d));
	ptc_dly #(.W(64), .N(MUL_LAT)) u_dly_v1p2 (.clk(clk), .en(en), .d(v1p2), .q(v1p2_d));

	// Raw pressure rides along to stage 8
	logic [19:0] rp_d;

	ptc_dly #(.W(20), .N(8)) u_dly_rp (
		.clk(clk), .en(en), .d(in_data.raw_pressure), .q(rp_d)
	);

	// Stage 8: sum the var2 and var1 terms
	logic [63:0] v2_s8;
	logic [63:0] v1c_s8;
	logic [63:0] sqp3_sh;

	assign sqp3_sh = $signed(sqp3) >>> 8;

	always_ff @(posedge clk) begin
		if (en) begin
			v2_s8  <= sqp6 + (v1p5_d << 17) + (p4 << 35);
			v1c_s8 <= sqp3_sh + (v1p2_d << 12);
		end
	end

	// Stage 9: bias var1, form the numerator base
	logic [63:0] x_s9;
	logic [63:0] nb_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s9  <= VAR1_BIAS + v1c_s8;
			nb_s9 <= ((PRESS_FULL - {44'b0, rp_d}) << 31) - v2_s8;
		end
	end

	// Stages 10-11: divisor and numerator products
	logic [63:0] xp1;
	logic [63:0] nsc;

	ptc_mul64 u_mul_p1 (.clk(clk), .en(en), .a(x_s9), .b(p1), .p(xp1));
	ptc_mul64 u_mul_sc (.clk(clk), .en(en), .a(nb_s9), .b(PRESS_SCALE), .p(nsc));

	// Stage 12: divisor, zero check
	logic [63:0] den_c;
	logic [63:0] den_s12;
	logic [63:0] num_s12;
	logic        dz_s12;

	assign den_c = $signed(xp1) >>> 33;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s12 <= den_c;
			num_s12 <= nsc;
			dz_s12  <= den_c == '0;
		end
	end

	// Stage 13: magnitudes and quotient sign
	logic [63:0] num_mag_s13;
	logic [63:0] den_mag_s13;
	logic        neg_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			num_mag_s13 <= num_s12[63] ? -num_s12 : num_s12;
			den_mag_s13 <= den_s12[63] ? -den_s12 : den_s12;
			neg_s13     <= num_s12[63] ^ den_s12[63];
		end
	end

	// Stages 14-77: divider
	logic [63:0] quo;
	logic        neg_d;

	ptc_div u_div (.clk(clk), .en(en), .num(num_mag_s13), .den(den_mag_s13), .quo(quo));
	ptc_dly #(.W(1), .N(DATA_W)) u_dly_neg (.clk(clk), .en(en), .d(neg_s13), .q(neg_d));

	// Stage 78: signed quotient
	logic [63:0] p_s78;
	logic [63:0] q13;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s78 <= neg_d ? -quo : quo;
		end
	end

	assign q13 = $signed(p_s78) >>> 13;

	// Stages 79-82: correction products
	logic [63:0] qq;
	logic [63:0] pp8;
	logic [63:0] qqp9;
	logic [63:0] pp8_d;
	logic [63:0] p_d;

	ptc_mul64 u_mul_qq (.clk(clk), .en(en), .a(q13), .b(q13), .p(qq));
	ptc_mul64 u_mul_p8 (.clk(clk), .en(en), .a(p_s78), .b(p8), .p(pp8));
	ptc_mul64 u_mul_p9 (.clk(clk), .en(en), .a(qq), .b(p9), .p(qqp9));
	ptc_dly #(.W(64), .N(MUL_LAT)) u_dly_pp8 (.clk(clk), .en(en), .d(pp8), .q(pp8_d));
	ptc_dly #(.W(64), .N(2 * MUL_LAT)) u_dly_p (.clk(clk), .en(en), .d(p_s78), .q(p_d));

	// Stage 83: sum the corrections
	logic [63:0] ca;
	logic [63:0] cb;
	logic [63:0] sum_s83;

	assign ca = $signed(qqp9) >>> 25;
	assign cb = $signed(pp8_d) >>> 19;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s83 <= p_d + ca + cb;
		end
	end

	// Temperature and zero flag ride along to stage 83
	logic [31:0] temp_d;
	logic        dz_d;

	ptc_dly #(.W(32), .N(80)) u_dly_temp (.clk(clk), .en(en), .d(temp_s3), .q(temp_d));
	ptc_dly #(.W(1), .N(71)) u_dly_dz (.clk(clk), .en(en), .d(dz_s12), .q(dz_d));

	// Stage 84: output register
	logic [63:0] sum_sh;
	logic [63:0] press;
	out_item_t   out_s84;

	// Keep the shift arithmetic on its own before mixing with unsigned terms.
	assign sum_sh = $signed(sum_s83) >>> 8;
	assign press  = sum_sh + (p7 << 4);

	always_ff @(posedge clk) begin
		if (en) begin
			out_s84.temperature_centi <= $signed(temp_d);
			out_s84.pressure_q24_8    <= dz_d ? 32'd0 : press[31:0];
			out_s84.divisor_zero      <= dz_d;
		end
	end

	assign out_data = out_s84;

endmodule

// ===== rtl/ptc_chk.sv =====
`timescale 1ns / 1ps
`include "pressure_temperature_compensation_core_assert.svh"
module ptc_chk
	import ptc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	`PTC_ASSERT_SAME(a_stall_blocks_in, out_valid && !out_ready, !in_ready)
	`PTC_ASSERT_SAME(a_idle_takes_in, !out_valid, in_ready)
	`PTC_ASSERT_SAME(a_zero_div_press, out_valid && out_data.divisor_zero, out_data.pressure_q24_8 == '0)
	`PTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind pressure_temperature_compensation_core ptc_chk u_ptc_chk (.*);
